@@ design/hse_pkg.sv @@
// Shared constants and transaction types for the Huffman symbol encoder/packer.
// Used by every module of the block; depends on nothing.
package hse_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int WORD_BITS    = 32;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT    = (WORD_BITS < MAX_CODE_LEN) ? WORD_BITS : MAX_CODE_LEN;

  localparam int SYM_W  = 8;                       // symbol field width
  localparam int CODE_W = 32;                      // code field width
  localparam int LEN_W  = 6;                       // code length / valid bit count width
  localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int FILL_W = $clog2(WORD_BITS);       // width of the count of bits held in the accumulator

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  // Encode transaction after table lookup
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;   // zero: no code for this symbol
    logic              last;
  } hse_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [LEN_W-1:0]     valid_bits;
    logic                 final_word;
    logic                 missing_code;
  } hse_result_t;

endpackage

@@ design/huffman_symbol_encoder_packer.sv @@
// Top level of the Huffman symbol encoder with bit packer.
// Instantiates hse_front, hse_queue and hse_back; depends on hse_pkg.
//
//   channel | dir | tdata (low bit up)                          | tlast       | tuser
//   in_     | in  | symbol[7:0] code_bits[39:8] code_length[45:40] | last_symbol | req_type
//   out_    | out | packed_word[31:0] valid_bits[37:32]          | final_word  | missing_code
//
// One input transaction per cycle unless the held lookup is stalled; loads complete at
// acceptance. An encode is looked up into the table read register, then written into
// the two-entry queue, whose head feeds the packer; each result is registered.
// An encode yielding a word plus a flush, or a missing code plus a flush, holds the
// packer for both results, one at a time on the single output register.
// Reset is synchronous, active low; it clears the table valid bits, accumulator and
// queue at once, so no clearing pass is needed. Output stalls back up into the queue.
module huffman_symbol_encoder_packer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hse_pkg::IN_TDATA_W-1:0]  in_tdata,   // symbol, code_bits, code_length, pad
  input  logic                            in_tlast,
  input  logic                            in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hse_pkg::OUT_TDATA_W-1:0] out_tdata,  // packed_word, valid_bits, pad
  output logic                            out_tlast,
  output logic                            out_tuser   // missing_code
);

  logic                 fr_valid;
  logic                 fr_ready;
  hse_pkg::hse_item_t   fr_item;
  logic                 q_valid;
  logic                 q_pop;
  hse_pkg::hse_item_t   q_item;
  hse_pkg::hse_result_t res;

  hse_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req_type    (in_tuser),
    .symbol      (in_tdata[7:0]),
    .code_bits   (in_tdata[39:8]),
    .code_length (in_tdata[45:40]),
    .last_symbol (in_tlast),
    .item_valid  (fr_valid),
    .item_ready  (fr_ready),
    .item        (fr_item)
  );

  hse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  hse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_item),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {2'b00, res.valid_bits, res.word};
  assign out_tlast = res.final_word;
  assign out_tuser = res.missing_code;

endmodule

@@ design/hse_front.sv @@
// Front end: accepts input transactions, keeps the code/length table and looks up
// encode symbols into a holding stage. Depends on hse_pkg.
module hse_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [hse_pkg::SYM_W-1:0]         symbol,
  input  logic [hse_pkg::CODE_W-1:0]        code_bits,
  input  logic [hse_pkg::LEN_W-1:0]         code_length,
  input  logic                              last_symbol,
  output logic                              item_valid,
  input  logic                              item_ready,
  output hse_pkg::hse_item_t                item
);

  localparam int ROW_W = hse_pkg::LEN_W + hse_pkg::CODE_W;

  logic [ROW_W-1:0]                  tab_mem [hse_pkg::SYMBOL_COUNT];
  logic [ROW_W-1:0]                  rd_r;
  logic [hse_pkg::SYMBOL_COUNT-1:0]  ent_v_r;
  logic                              s1_v_r;
  logic                              s1_ent_v_r;
  logic                              s1_last_r;

  logic                              accept;
  logic                              load_acc;
  logic                              enc_acc;
  logic                              in_range;
  logic [hse_pkg::IDX_W-1:0]         idx;
  logic [hse_pkg::LEN_W-1:0]         len_sat;
  logic [hse_pkg::CODE_W-1:0]        code_mask;

  assign in_ready = !s1_v_r || item_ready;
  assign accept   = in_valid && in_ready;
  assign load_acc = accept && (req_type == hse_pkg::REQ_LOAD);
  assign enc_acc  = accept && (req_type == hse_pkg::REQ_ENCODE);
  assign in_range = ({1'b0, symbol} < (hse_pkg::SYM_W + 1)'(hse_pkg::SYMBOL_COUNT));
  assign idx      = hse_pkg::IDX_W'(symbol);

  // Saturate the length, then keep only that many low bits of the code
  always_comb begin
    if (code_length > hse_pkg::LEN_W'(hse_pkg::LEN_LIMIT)) begin
      len_sat = hse_pkg::LEN_W'(hse_pkg::LEN_LIMIT);
    end else begin
      len_sat = code_length;
    end
    code_mask = ~({hse_pkg::CODE_W{1'b1}} << len_sat);
  end

  always_ff @(posedge clk) begin
    if (load_acc && in_range) begin
      tab_mem[idx] <= {len_sat, code_bits & code_mask};
    end
    if (enc_acc) begin
      rd_r <= tab_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r    <= '0;
      s1_v_r     <= 1'b0;
      s1_ent_v_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      if (load_acc && in_range) begin
        ent_v_r[idx] <= 1'b1;
      end
      if (enc_acc) begin
        s1_v_r     <= 1'b1;
        s1_ent_v_r <= in_range && ent_v_r[idx];
        s1_last_r  <= last_symbol;
      end else if (item_ready) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  assign item_valid = s1_v_r;
  assign item.code  = rd_r[hse_pkg::CODE_W-1:0];
  assign item.len   = s1_ent_v_r ? rd_r[ROW_W-1:hse_pkg::CODE_W] : '0;
  assign item.last  = s1_last_r;

endmodule

@@ design/hse_queue.sv @@
// Short transaction queue between the lookup front end and the packer.
// Depends on hse_pkg for depth and the item type.
module hse_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hse_pkg::hse_item_t push_item,
  output logic               pop_valid,
  input  logic               pop,
  output hse_pkg::hse_item_t pop_item
);

  hse_pkg::hse_item_t               q_mem [hse_pkg::QUEUE_DEPTH];
  logic [hse_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [hse_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [hse_pkg::QCNT_W-1:0]       count_r;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count_r != hse_pkg::QCNT_W'(hse_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = q_mem[rd_ptr_r];

  function automatic logic [hse_pkg::QPTR_W-1:0] ptr_inc(input logic [hse_pkg::QPTR_W-1:0] p);
    if (p == hse_pkg::QPTR_W'(hse_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + hse_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + hse_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - hse_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ design/hse_back.sv @@
// Back end: appends looked-up codes to the bit accumulator and drives the
// registered result stage. Depends on hse_pkg.
module hse_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  hse_pkg::hse_item_t   head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hse_pkg::hse_result_t out_res
);

  localparam int W = hse_pkg::WORD_BITS;
  localparam int C = hse_pkg::LEN_W;

  logic [W-1:0]              acc_r,   acc_nxt;
  logic [hse_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                      flush_r, flush_nxt;   // second transaction of this item pending
  logic                      out_v_r;
  hse_pkg::hse_result_t      out_r;

  logic                      slot_free;
  logic                      res_v;
  hse_pkg::hse_result_t      res;
  logic [C-1:0]              total;
  logic [C-1:0]              over;
  logic [W-1:0]              acc_app;

  assign slot_free = !out_v_r || out_ready;
  assign total     = C'(fill_r) + head.len;
  assign over      = total - C'(W);
  assign acc_app   = acc_r | (head.code << (C'(W) - total));

  always_comb begin
    pop       = 1'b0;
    res_v     = 1'b0;
    res       = '0;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    if (head_valid) begin
      if (flush_r) begin
        if (slot_free) begin
          res.word       = acc_r;
          res.valid_bits = C'(fill_r);
          res.final_word = 1'b1;
          res_v          = 1'b1;
          acc_nxt        = '0;
          fill_nxt       = '0;
          flush_nxt      = 1'b0;
          pop            = 1'b1;
        end
      end else if (head.len == '0) begin
        // no code: report it, leave the accumulator as it is
        if (slot_free) begin
          res.missing_code = 1'b1;
          res_v            = 1'b1;
          if (head.last) begin
            flush_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end else if (total < C'(W)) begin
        if (head.last) begin
          if (slot_free) begin
            res.word       = acc_app;
            res.valid_bits = total;
            res.final_word = 1'b1;
            res_v          = 1'b1;
            acc_nxt        = '0;
            fill_nxt       = '0;
            pop            = 1'b1;
          end
        end else begin
          acc_nxt  = acc_app;
          fill_nxt = hse_pkg::FILL_W'(total);
          pop      = 1'b1;
        end
      end else if (total == C'(W)) begin
        if (slot_free) begin
          res.word       = acc_r | head.code;
          res.valid_bits = C'(W);
          res.final_word = head.last;
          res_v          = 1'b1;
          acc_nxt        = '0;
          fill_nxt       = '0;
          pop            = 1'b1;
        end
      end else begin
        // word overflows: emit it, keep the low spill bits at the top
        if (slot_free) begin
          res.word       = acc_r | (head.code >> over);
          res.valid_bits = C'(W);
          res_v          = 1'b1;
          acc_nxt        = head.code << (C'(W) - over);
          fill_nxt       = hse_pkg::FILL_W'(over);
          if (head.last) begin
            flush_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      fill_r  <= '0;
      flush_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
      if (res_v) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

@@ verif/huffman_symbol_encoder_packer_tb.sv @@
// Self-checking testbench for huffman_symbol_encoder_packer: table loads and
// encode streams in, packed words checked against an in-bench packer model.
// Depends on hse_pkg and the huffman_symbol_encoder_packer RTL.
module huffman_symbol_encoder_packer_tb;

  typedef struct packed {
    logic                      req;
    logic [hse_pkg::SYM_W-1:0]  sym;
    logic [hse_pkg::CODE_W-1:0] code;
    logic [hse_pkg::LEN_W-1:0]  len;
    logic                      last;
  } sym_req_t;

  class packed_word_tracker;
    bit [hse_pkg::CODE_W-1:0] code_mem [hse_pkg::SYMBOL_COUNT];
    bit [hse_pkg::LEN_W-1:0]  len_mem  [hse_pkg::SYMBOL_COUNT];
    bit [63:0]                word_mask = (64'd1 << hse_pkg::WORD_BITS) - 64'd1;
    bit [63:0]                acc;
    int unsigned              fill;
    hse_pkg::hse_result_t     pending_words[$];
    int                       mismatches;
    int                       loads, encodes, results, missing_seen, stream_ends;

    function void push_word(bit [63:0] w, int unsigned v, bit f, bit m);
      hse_pkg::hse_result_t r;
      r.word         = w[hse_pkg::WORD_BITS-1:0];
      r.valid_bits   = hse_pkg::LEN_W'(v);
      r.final_word   = f;
      r.missing_code = m;
      pending_words.push_back(r);
    endfunction

    // Work out the words that one accepted transaction will produce
    function void absorb_item(sym_req_t it);
      bit [hse_pkg::LEN_W-1:0] len;
      bit [63:0]               code;
      int unsigned             total;
      int unsigned             over;
      bit                      emitted;
      emitted = 1'b0;
      if (it.req == hse_pkg::REQ_LOAD) begin
        loads++;
        len = (int'(it.len) > hse_pkg::LEN_LIMIT) ? hse_pkg::LEN_W'(hse_pkg::LEN_LIMIT) : it.len;
        code_mem[it.sym] = it.code & hse_pkg::CODE_W'((64'd1 << len) - 64'd1);
        len_mem[it.sym]  = len;
      end else begin
        encodes++;
        len  = len_mem[it.sym];
        code = 64'(code_mem[it.sym]);
        if (len == 0) begin
          push_word(64'd0, 0, 1'b0, 1'b1);
        end else begin
          total = fill + 32'(len);
          if (total < hse_pkg::WORD_BITS) begin
            acc  = acc | (code << (hse_pkg::WORD_BITS - total));
            fill = total;
          end else if (total == hse_pkg::WORD_BITS) begin
            push_word((acc | code) & word_mask, hse_pkg::WORD_BITS, it.last, 1'b0);
            acc     = 64'd0;
            fill    = 0;
            emitted = 1'b1;
          end else begin
            // split the code: head completes this word, tail starts the next
            over = total - hse_pkg::WORD_BITS;
            push_word((acc | (code >> over)) & word_mask, hse_pkg::WORD_BITS, 1'b0, 1'b0);
            acc     = (code << (hse_pkg::WORD_BITS - over)) & word_mask;
            fill    = over;
            emitted = 1'b1;
          end
        end
        if (it.last && (fill > 0 || !emitted)) begin
          push_word(acc & word_mask, fill, 1'b1, 1'b0);
          acc  = 64'd0;
          fill = 0;
        end
      end
    endfunction

    function void compare_word(hse_pkg::hse_result_t got);
      hse_pkg::hse_result_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %08h valid %0d final %0b missing %0b",
                 $time, got.word, got.valid_bits, got.final_word, got.missing_code);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        results++;
        if (want.missing_code) missing_seen++;
        if (want.final_word) stream_ends++;
        if (got.word !== want.word || got.valid_bits !== want.valid_bits ||
            got.final_word !== want.final_word || got.missing_code !== want.missing_code) begin
          $display("%0t: mismatch expected word %08h valid %0d final %0b missing %0b",
                   $time, want.word, want.valid_bits, want.final_word, want.missing_code);
          $display("%0t:          actual   word %08h valid %0d final %0b missing %0b",
                   $time, got.word, got.valid_bits, got.final_word, got.missing_code);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [hse_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hse_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  packed_word_tracker tracker = new;

  int unsigned sent;
  bit          sym_loaded [hse_pkg::SYMBOL_COUNT];
  logic [7:0]  loaded_list[$];
  bit          hold_request;

  huffman_symbol_encoder_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("huffman_symbol_encoder_packer regression: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sym_req_t load_req(logic [7:0] sym, logic [31:0] code, logic [5:0] len,
                                        logic last);
    sym_req_t it;
    it.req  = hse_pkg::REQ_LOAD;
    it.sym  = sym;
    it.code = code;
    it.len  = len;
    it.last = last;
    return it;
  endfunction

  function automatic sym_req_t encode_req(logic [7:0] sym, logic last);
    sym_req_t it;
    it.req  = hse_pkg::REQ_ENCODE;
    it.sym  = sym;
    it.code = $urandom;
    it.len  = 6'($urandom_range(0, 63));
    it.last = last;
    return it;
  endfunction

  function automatic sym_req_t random_load();
    int unsigned r;
    logic [5:0]  len;
    r = $urandom_range(0, 99);
    if (r < 8)       len = 6'd0;
    else if (r < 80) len = 6'($urandom_range(1, 10));
    else if (r < 95) len = 6'($urandom_range(11, 32));
    else             len = 6'($urandom_range(33, 63));
    return load_req(8'($urandom_range(0, 255)), $urandom, len, 1'($urandom_range(0, 1)));
  endfunction

  // Idle for a random gap, then hold the transaction until it is taken
  task automatic offer_request(sym_req_t it);
    int unsigned gap;
    gap = pick_gap();
    if (((sent / 64) % 4) == 3) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (it.req == hse_pkg::REQ_LOAD && !sym_loaded[it.sym]) begin
      sym_loaded[it.sym] = 1'b1;
      loaded_list.push_back(it.sym);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= hse_pkg::IN_TDATA_W'({it.len, it.code, it.sym});
    in_tlast  <= it.last;
    in_tuser  <= it.req;
    do @(posedge clk); while (!in_tready);
    tracker.absorb_item(it);
    sent++;
  endtask

  initial begin : result_sink
    int unsigned          stall_left;
    int unsigned          cyc;
    hse_pkg::hse_result_t got;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_tvalid && out_tready) begin
        got.word         = out_tdata[hse_pkg::WORD_BITS-1:0];
        got.valid_bits   = out_tdata[hse_pkg::WORD_BITS +: hse_pkg::LEN_W];
        got.final_word   = out_tlast;
        got.missing_code = out_tuser;
        tracker.compare_word(got);
      end
      if (hold_request) begin
        // long hold-off: let the block back up into its input
        hold_request = 1'b0;
        stall_left   = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (((cyc / 256) % 4) == 2) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : stimulus
    sym_req_t    directed[$];
    int unsigned msg_len;
    int unsigned drain;
    bit          hold_done;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // loads: full length, masked code with last ignored, saturated length,
    // no code, short code, 31-bit code
    directed.push_back(load_req(8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0));
    directed.push_back(load_req(8'hFF, 32'hFFFF_FFFF, 6'd1,  1'b1));
    directed.push_back(load_req(8'h55, 32'hA5A5_A5A5, 6'd63, 1'b0));
    directed.push_back(load_req(8'hAA, 32'h5A5A_5A5A, 6'd0,  1'b0));
    directed.push_back(load_req(8'h07, 32'h0000_0013, 6'd5,  1'b0));
    directed.push_back(load_req(8'h80, 32'h7FFF_FFFF, 6'd31, 1'b0));
    // word straddle, missing mid-stream, flush of a partial word
    directed.push_back(encode_req(8'hFF, 1'b0));
    directed.push_back(encode_req(8'h07, 1'b0));
    directed.push_back(encode_req(8'h00, 1'b0));
    directed.push_back(encode_req(8'hAA, 1'b0));
    directed.push_back(encode_req(8'h07, 1'b1));
    // exact fill on the last item, then missing code with an empty flush
    directed.push_back(encode_req(8'h00, 1'b1));
    directed.push_back(encode_req(8'hAA, 1'b1));
    directed.push_back(encode_req(8'h80, 1'b0));
    directed.push_back(encode_req(8'hFF, 1'b1));
    directed.push_back(encode_req(8'h55, 1'b0));
    directed.push_back(encode_req(8'h55, 1'b1));
    // straddle on the last item leaves a tail to flush
    directed.push_back(encode_req(8'h07, 1'b0));
    directed.push_back(encode_req(8'h55, 1'b1));
    directed.push_back(encode_req(8'hFF, 1'b1));
    foreach (directed[i]) offer_request(directed[i]);

    // well-formed messages over a changing alphabet, with stray loads and early ends
    while (sent < 720) begin
      if (loaded_list.size() == 0 || $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) offer_request(random_load());
      if (!hold_done && sent >= 200) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 19) == 0) offer_request(random_load());
        offer_request(encode_req(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                                 (i == msg_len - 1) || ($urandom_range(0, 49) == 0)));
      end
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (tracker.pending_words.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    if (tracker.pending_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, tracker.pending_words.size());
      tracker.mismatches += tracker.pending_words.size();
    end
    $display("covered %0d table loads and %0d encodes over %0d symbols",
             tracker.loads, tracker.encodes, loaded_list.size());
    $display("checked %0d words: %0d missing-code, %0d end-of-stream, %0d mismatches",
             tracker.results, tracker.missing_seen, tracker.stream_ends, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("huffman_symbol_encoder_packer regression: pass");
    end else begin
      $display("huffman_symbol_encoder_packer regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/hse_pkg.sv
design/hse_front.sv
design/hse_queue.sv
design/hse_back.sv
design/huffman_symbol_encoder_packer.sv
verif/huffman_symbol_encoder_packer_tb.sv
